### hw/rtl/u8w16_pkg.sv
// ============================================================================
// u8w16_pkg
// Shared constants and types for the UTF-8 to WTF-16 transcoder.
// ============================================================================
package u8w16_pkg;

    localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    // Default depth of the queue between decoder and output stage
    localparam int QUEUE_DEPTH = 4;

    // One decoded byte: one or two code units
    typedef struct packed {
        logic [15:0] unit0;
        logic [15:0] unit1;
        logic        two;
        logic        last;
    } t_rec;

endpackage

### hw/rtl/u8w16_in_if.sv
// ============================================================================
// u8w16_in_if
// Byte channel: one UTF-8 byte per beat with an end-of-string flag.
// ============================================================================
interface u8w16_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

### hw/rtl/u8w16_out_if.sv
// ============================================================================
// u8w16_out_if
// Unit channel: one WTF-16 code unit per beat with item and string markers.
// ============================================================================
interface u8w16_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last_of_item;
    logic        last_of_string;

    modport source (output valid, output code_unit, output last_of_item,
                    output last_of_string, input ready);
    modport sink   (input valid, input code_unit, input last_of_item,
                    input last_of_string, output ready);
endinterface

### hw/rtl/u8w16_front.sv
// ============================================================================
// u8w16_front
// Byte decoder: tracks the partial code point, forms zero, one or two units per
// accepted byte and pushes any units as one record into the queue.
// ============================================================================
module u8w16_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    u8w16_in_if.sink          i_in,
    input  logic              i_q_ready,
    output logic              o_push,
    output u8w16_pkg::t_rec   o_rec
);

    logic [20:0] r_cp;
    logic [20:0] n_cp;
    logic [1:0]  r_due;
    logic [1:0]  n_due;

    logic [7:0]  b;
    logic [20:0] cp_done;
    logic [20:0] cp_off;
    logic [15:0] surr_hi;
    logic [15:0] surr_lo;
    logic        take_lead;
    logic [1:0]  cnt;
    logic [15:0] u0;
    logic [15:0] u1;
    logic        accept;

    assign b       = i_in.byte_value;
    assign cp_done = {r_cp[14:0], b[5:0]};
    assign cp_off  = cp_done - u8w16_pkg::SUPP_BASE;
    assign surr_hi = u8w16_pkg::SURR_HI_BASE + {5'd0, cp_off[20:10]};
    assign surr_lo = u8w16_pkg::SURR_LO_BASE | {6'd0, cp_off[9:0]};

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_q_ready;

    always_comb begin
        n_cp      = r_cp;
        n_due     = r_due;
        cnt       = 2'd0;
        u0        = '0;
        u1        = '0;
        take_lead = 1'b0;

        if (r_due != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                n_cp  = cp_done;
                n_due = r_due - 2'd1;
                if (n_due == 2'd0) begin
                    n_cp = '0;
                    if (cp_done[20:16] == 5'd0) begin
                        u0  = cp_done[15:0];
                        cnt = 2'd1;
                    end else begin
                        u0  = surr_hi;
                        u1  = surr_lo;
                        cnt = 2'd2;
                    end
                end
            end else begin
                // broken sequence: replace it, then reparse this byte as a lead
                u0        = u8w16_pkg::REPL_UNIT;
                cnt       = 2'd1;
                n_due     = 2'd0;
                n_cp      = '0;
                take_lead = 1'b1;
            end
        end else begin
            take_lead = 1'b1;
        end

        if (take_lead) begin
            if (b[7] == 1'b0) begin
                if (cnt == 2'd0) u0 = {8'd0, b};
                else             u1 = {8'd0, b};
                cnt = cnt + 2'd1;
            end else if (b[7:5] == 3'b110) begin
                n_cp  = {16'd0, b[4:0]};
                n_due = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                n_cp  = {17'd0, b[3:0]};
                n_due = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                n_cp  = {18'd0, b[2:0]};
                n_due = 2'd3;
            end else begin
                if (cnt == 2'd0) u0 = u8w16_pkg::REPL_UNIT;
                else             u1 = u8w16_pkg::REPL_UNIT;
                cnt = cnt + 2'd1;
            end
        end

        if (i_in.last_byte) begin
            // sequence cut off at end of string
            if (n_due != 2'd0) begin
                if (cnt == 2'd0) u0 = u8w16_pkg::REPL_UNIT;
                else             u1 = u8w16_pkg::REPL_UNIT;
                cnt = cnt + 2'd1;
            end
            n_due = 2'd0;
            n_cp  = '0;
        end
    end

    assign o_push     = accept && (cnt != 2'd0);
    assign o_rec.unit0 = u0;
    assign o_rec.unit1 = u1;
    assign o_rec.two   = (cnt == 2'd2);
    assign o_rec.last  = i_in.last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp  <= '0;
            r_due <= '0;
        end else if (accept) begin
            r_cp  <= n_cp;
            r_due <= n_due;
        end
    end

endmodule

### hw/rtl/u8w16_queue.sv
// ============================================================================
// u8w16_queue
// Small register queue of decoded records between decoder and output stage.
// ============================================================================
module u8w16_queue #(
    parameter int DEPTH = u8w16_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  u8w16_pkg::t_rec   i_rec,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output u8w16_pkg::t_rec   o_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u8w16_pkg::t_rec   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/u8w16_back.sv
// ============================================================================
// u8w16_back
// Output stage: pops records and sends their units one beat at a time from
// an output register.
// ============================================================================
module u8w16_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  u8w16_pkg::t_rec   i_q_rec,
    output logic              o_pop,
    u8w16_out_if.source       o_out
);

    logic        r_valid;
    logic [15:0] r_unit;
    logic        r_last_item;
    logic        r_last_str;
    logic        r_pend;
    logic [15:0] r_pend_unit;
    logic        r_pend_last;
    logic        load_ok;

    assign load_ok = !r_valid || o_out.ready;
    assign o_pop   = load_ok && !r_pend && i_q_valid;

    assign o_out.valid          = r_valid;
    assign o_out.code_unit      = r_unit;
    assign o_out.last_of_item   = r_last_item;
    assign o_out.last_of_string = r_last_str;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load_ok) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else begin
                r_valid <= i_q_valid;
                r_pend  <= i_q_valid && i_q_rec.two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            if (r_pend) begin
                // second unit of a pair
                r_unit      <= r_pend_unit;
                r_last_item <= 1'b1;
                r_last_str  <= r_pend_last;
            end else if (i_q_valid) begin
                r_unit      <= i_q_rec.unit0;
                r_last_item <= !i_q_rec.two;
                r_last_str  <= i_q_rec.last && !i_q_rec.two;
                r_pend_unit <= i_q_rec.unit1;
                r_pend_last <= i_q_rec.last;
            end
        end
    end

endmodule

### hw/rtl/utf8_to_wtf16_transcoder.sv
// ============================================================================
// utf8_to_wtf16_transcoder
// UTF-8 byte stream to WTF-16 code units, errors replaced by 0xFFFD.
// ============================================================================
//  Port     Dir   Beat carries
//  i_in     in    byte_value[7:0], last_byte
//  o_out    out   code_unit[15:0], last_of_item, last_of_string
//
//  A byte is taken every cycle while the record queue has room; each byte
//  yields zero, one or two units, and the output register sends one unit per
//  cycle while o_out is ready, so the two units of a pair leave as separate beats.
//  A byte's first unit is registered in the queue, then in the output register.
//  Reset (synchronous, active low) empties the queue and clears the decoder.
//  Output stalls back up through the queue to i_in.ready.
// ============================================================================
module utf8_to_wtf16_transcoder #(
    parameter int QUEUE_DEPTH = u8w16_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    u8w16_in_if.sink     i_in,
    u8w16_out_if.source  o_out
);

    logic              push;
    logic              q_ready;
    logic              q_valid;
    logic              pop;
    u8w16_pkg::t_rec   push_rec;
    u8w16_pkg::t_rec   head_rec;

    u8w16_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_rec     (push_rec)
    );

    u8w16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rec   (head_rec)
    );

    u8w16_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_rec   (head_rec),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
